// File: sv/weekly_hour_schedule_trigger_assert.svh
// ----------------------------------------------------------------------------
// Weekly hour schedule trigger assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_HOUR_SCHEDULE_TRIGGER_ASSERT_SVH
`define WEEKLY_HOUR_SCHEDULE_TRIGGER_ASSERT_SVH

// Overlapping implication, checked while out of reset.
`define WHST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weekly hour schedule trigger check failed");

// Next-cycle implication, checked while out of reset.
`define WHST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weekly hour schedule trigger check failed");

`endif

// File: sv/whst_pkg.sv
// ----------------------------------------------------------------------------
// Weekly hour schedule trigger package
// Beat types, codes and helpers shared by the block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package whst_pkg;

  localparam int unsigned DAYS  = 7;
  localparam int unsigned HOURS = 24;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MASK   = 2'd1;
  localparam logic [1:0] OP_ACTION = 2'd2;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;

  localparam logic [2:0] ACT_CUR_6A  = 3'd2;
  localparam logic [2:0] ACT_CUR_8A  = 3'd3;
  localparam logic [2:0] ACT_CUR_10A = 3'd4;

  localparam logic [6:0] TENTHS_6A  = 7'd60;
  localparam logic [6:0] TENTHS_8A  = 7'd80;
  localparam logic [6:0] TENTHS_10A = 7'd100;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [23:0] hour_mask;
    logic [2:0]  action_code;
  } in_t;

  typedef struct packed {
    logic [3:0] event_slot;
    logic [2:0] event_action;
    logic       switch_on;
    logic [6:0] current_tenths;
    logic       restore_default;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } st_e;

  function automatic logic is_current(input logic [2:0] act);
    is_current = (act == ACT_CUR_6A) || (act == ACT_CUR_8A) || (act == ACT_CUR_10A);
  endfunction

  function automatic logic [6:0] on_current(input logic [2:0] act);
    logic [6:0] t;
    t = '0;
    if (act == ACT_CUR_6A) begin
      t = TENTHS_6A;
    end else if (act == ACT_CUR_8A) begin
      t = TENTHS_8A;
    end else if (act == ACT_CUR_10A) begin
      t = TENTHS_10A;
    end
    on_current = t;
  endfunction

endpackage

`default_nettype wire

// File: sv/weekly_hour_schedule_trigger.sv
// ----------------------------------------------------------------------------
// Weekly hour schedule trigger
// Holds weekly hour masks and actions per slot and reports phase changes on
// each hour tick.
// ----------------------------------------------------------------------------
// Load beats (hour mask or action) complete without leaving the idle state. A tick
// walks slots 0 to min(configured slot count, MAX_SCHEDULES)-1 at one slot per cycle
// while the result port does not stall, bounded by the read-modify-write of the slot
// memory; a stalled result port holds the walk. If the walk has an event to release,
// the tick then passes through the flush state to release its final event. A tick with no
// slot to walk or with weekday seven is taken without leaving the idle state. Hour masks and
// actions are undefined until loaded; phases read as none after reset.
`timescale 1ns / 1ps
`default_nettype none

module weekly_hour_schedule_trigger #(
  parameter int unsigned MAX_SCHEDULES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  output      logic           cfg_ready_o,
  input  wire logic [4:0]     cfg_data_i,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire whst_pkg::in_t  in_data_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output whst_pkg::out_t      out_data_o
);
  import whst_pkg::*;

  localparam int unsigned SW = (MAX_SCHEDULES > 1) ? $clog2(MAX_SCHEDULES) : 1;
  localparam int unsigned MD = MAX_SCHEDULES * DAYS;
  localparam int unsigned AW = $clog2(MD);

  logic [23:0]   mask_mem [MD];
  logic [4:0]    slot_mem [MAX_SCHEDULES];

  st_e           st_q, st_d;
  logic [4:0]    count_q;
  logic [SW-1:0] idx_q, idx_d, last_q, last_d, rd_idx;
  logic [2:0]    wday_q, wday_d;
  logic [4:0]    hour_q, hour_d;
  logic [23:0]   mask_rd_q;
  logic [4:0]    slot_rd_q;
  logic [MAX_SCHEDULES-1:0] ph_vld_q;
  out_t          pend_q, pend_d, out_q, out_d;
  logic          pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;

  logic          in_acc, slot_ok, is_tick, mask_we, slot_ld, slot_we;
  logic [4:0]    cnt_clip;
  logic [AW-1:0] mask_waddr, mask_raddr;
  logic [SW-1:0] slot_waddr;
  logic [4:0]    slot_wdata;
  logic [2:0]    rd_act;
  logic [1:0]    cur_ph;
  logic          hit, need, out_free, adv, at_last, push, push_last;
  out_t          ev;

  function automatic logic [AW-1:0] mask_addr(input logic [SW-1:0] s, input logic [2:0] wd);
    mask_addr = AW'((32'(s) << 3) - 32'(s) + 32'(wd));
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cnt_clip = (32'(count_q) > MAX_SCHEDULES) ? 5'(MAX_SCHEDULES) : count_q;
  assign slot_ok  = 32'(in_data_i.slot) < MAX_SCHEDULES;
  assign is_tick  = in_acc && (in_data_i.op == OP_TICK) && (32'(in_data_i.weekday) < DAYS)
                    && (cnt_clip != 5'd0);
  assign mask_we  = in_acc && (in_data_i.op == OP_MASK) && slot_ok
                    && (32'(in_data_i.weekday) < DAYS);
  assign slot_ld  = in_acc && (in_data_i.op == OP_ACTION) && slot_ok;

  assign rd_act   = slot_rd_q[4:2];
  assign cur_ph   = ph_vld_q[idx_q] ? slot_rd_q[1:0] : PH_NONE;
  assign hit      = (32'(hour_q) < HOURS) && mask_rd_q[hour_q];
  assign need     = hit ? (cur_ph != PH_ON) : (cur_ph != PH_OFF);
  assign out_free = !out_vld_q || out_ready_i;
  assign adv      = !need || !pend_vld_q || out_free;
  assign at_last  = (idx_q == last_q);

  always_comb begin
    ev.event_slot      = 4'(idx_q);
    ev.event_action    = rd_act;
    ev.switch_on       = hit;
    ev.current_tenths  = hit ? on_current(rd_act) : 7'd0;
    ev.restore_default = !hit && is_current(rd_act);
    ev.last            = 1'b0;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (is_tick) begin
          st_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (adv && at_last) begin
          st_d = (need || pend_vld_q) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    last_d     = last_q;
    wday_d     = wday_q;
    hour_d     = hour_q;
    rd_idx     = '0;
    mask_raddr = mask_addr('0, in_data_i.weekday);
    slot_we    = 1'b0;
    slot_waddr = SW'(in_data_i.slot);
    slot_wdata = {in_data_i.action_code, PH_NONE};
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    push       = 1'b0;
    push_last  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        slot_we = slot_ld;
        if (is_tick) begin
          idx_d  = '0;
          last_d = SW'(32'(cnt_clip) - 32'd1);
          wday_d = in_data_i.weekday;
          hour_d = in_data_i.hour;
        end
      end
      ST_WALK: begin
        rd_idx     = (adv && !at_last) ? idx_q + SW'(1) : idx_q;
        mask_raddr = mask_addr(rd_idx, wday_q);
        slot_waddr = idx_q;
        slot_wdata = {rd_act, hit ? PH_ON : PH_OFF};
        if (adv) begin
          idx_d = rd_idx;
          if (need) begin
            slot_we    = 1'b1;
            push       = pend_vld_q;
            pend_d     = ev;
            pend_vld_d = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        pend_vld_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    if (push) begin
      out_d      = pend_q;
      out_d.last = push_last;
      out_vld_d  = 1'b1;
    end
  end

  assign mask_waddr = mask_addr(SW'(in_data_i.slot), in_data_i.weekday);

  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= in_data_i.hour_mask;
    end
    mask_rd_q <= mask_mem[mask_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      count_q    <= '0;
      ph_vld_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (slot_we) begin
        ph_vld_q[slot_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    wday_q <= wday_d;
    hour_q <= hour_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// File: sv/whst_checker.sv
// ----------------------------------------------------------------------------
// Weekly hour schedule trigger port checker
// Watches the ports of the block over time and flags illegal behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "weekly_hour_schedule_trigger_assert.svh"

module whst_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           cfg_valid_i,
  input wire logic           cfg_ready_o,
  input wire logic [4:0]     cfg_data_i,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire whst_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire whst_pkg::out_t out_data_o
);
  import whst_pkg::*;

  logic load_acc;
  logic cfg_seen;

  assign load_acc = in_valid_i && in_ready_o
                    && ((in_data_i.op == OP_MASK) || (in_data_i.op == OP_ACTION));
  assign cfg_seen = cfg_valid_i && cfg_ready_o;

  // A result beat that is not taken stays in place.
  `WHST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))

  // A load beat finishes at once and the block is ready again.
  `WHST_ASSERT_NXT(a_load_one_cycle, clk_i, rst_ni,
    load_acc || (cfg_seen && !in_valid_i && !out_valid_o && in_ready_o), in_ready_o)

  // While a tick still owes a final event, no new beat is taken.
  `WHST_ASSERT_IMP(a_busy_mid_tick, clk_i, rst_ni, out_valid_o && !out_data_o.last,
    !in_ready_o)

  // Turning on never restores the default, and turning off carries no current.
  `WHST_ASSERT_IMP(a_event_fields, clk_i, rst_ni, out_valid_o,
    (out_data_o.switch_on && !out_data_o.restore_default)
    || (!out_data_o.switch_on && (out_data_o.current_tenths == 7'd0)))

endmodule

bind weekly_hour_schedule_trigger whst_checker u_whst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: bench/weekly_hour_schedule_trigger_test.sv
// ----------------------------------------------------------------------------
// Weekly hour schedule trigger testbench
// Drives load and tick beats through the valid/ready input port and checks
// every event beat against a behavioral predictor of the schedule table.
// A short directed table comes first, then random traffic in several phases
// with different slot counts and idle patterns on both ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weekly_hour_schedule_trigger_test;

  import whst_pkg::*;

  localparam int unsigned MAX_SCHEDULES = 16;
  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_SCHEDULES + 8;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned PHASE_ITEMS   = 8;
  localparam int unsigned TICK_DAY_STEP = 3;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0] ACT_ENABLE    = 3'd0;
  localparam logic [2:0] ACT_AVAILABLE = 3'd1;
  localparam logic [2:0] ACT_UNKNOWN   = 3'd7;
  localparam logic [2:0] WDAY_NONE     = 3'd7;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic       is_cfg;
    logic [4:0] cfg_value;
    logic       typed;
    logic       has_event;
    in_t        beat;
    out_t       ev;
  } dir_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [4:0] cfg_data_i = '0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  logic [23:0] mask_mem   [MAX_SCHEDULES][DAYS];
  logic [2:0]  action_mem [MAX_SCHEDULES];
  logic [1:0]  phase_mem  [MAX_SCHEDULES];
  logic [4:0]  sched_count;

  out_t        tick_events[$];
  out_t        pending_events[$];
  dir_row_t    dir_rows[$];
  logic [4:0]  phase_counts [NUM_PHASES];
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  weekly_hour_schedule_trigger #(
    .MAX_SCHEDULES(MAX_SCHEDULES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready_i <= ($urandom_range(99) >= 52);
      IDLE_BOTH:     out_ready_i <= ($urandom_range(99) >= 8);
      default:       out_ready_i <= 1'b1;
    endcase
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event beat for slot %0d",
                                  out_data_o.event_slot));
      end else begin
        want = pending_events.pop_front();
        check_field("event_slot", 24'(out_data_o.event_slot), 24'(want.event_slot));
        check_field("event_action", 24'(out_data_o.event_action), 24'(want.event_action));
        check_field("switch_on", 24'(out_data_o.switch_on), 24'(want.switch_on));
        check_field("current_tenths", 24'(out_data_o.current_tenths),
                    24'(want.current_tenths));
        check_field("restore_default", 24'(out_data_o.restore_default),
                    24'(want.restore_default));
        check_field("last", 24'(out_data_o.last), 24'(want.last));
      end
    end
  end

  function automatic void predict_events(input in_t b);
    int unsigned walk;
    logic        hit;
    out_t        ev;
    tick_events.delete();
    case (b.op)
      OP_MASK: begin
        if (b.slot < MAX_SCHEDULES && b.weekday < DAYS) begin
          mask_mem[b.slot][b.weekday] = b.hour_mask;
        end
      end
      OP_ACTION: begin
        if (b.slot < MAX_SCHEDULES) begin
          action_mem[b.slot] = b.action_code;
          phase_mem[b.slot]  = PH_NONE;
        end
      end
      OP_TICK: begin
        if (b.weekday < DAYS) begin
          walk = (sched_count > MAX_SCHEDULES) ? MAX_SCHEDULES : sched_count;
          for (int s = 0; s < walk; s++) begin
            hit = 1'b0;
            if (b.hour < HOURS) begin
              hit = mask_mem[s][b.weekday][b.hour];
            end
            if (hit ? (phase_mem[s] == PH_ON) : (phase_mem[s] == PH_OFF)) begin
              continue;
            end
            phase_mem[s]       = hit ? PH_ON : PH_OFF;
            ev                 = '0;
            ev.event_slot      = 4'(s);
            ev.event_action    = action_mem[s];
            ev.switch_on       = hit;
            if (hit) begin
              case (action_mem[s])
                ACT_CUR_6A:  ev.current_tenths = TENTHS_6A;
                ACT_CUR_8A:  ev.current_tenths = TENTHS_8A;
                ACT_CUR_10A: ev.current_tenths = TENTHS_10A;
                default:     ev.current_tenths = '0;
              endcase
            end else begin
              ev.restore_default = (action_mem[s] == ACT_CUR_6A) ||
                                   (action_mem[s] == ACT_CUR_8A) ||
                                   (action_mem[s] == ACT_CUR_10A);
            end
            tick_events.push_back(ev);
          end
          if (tick_events.size() > 0) begin
            tick_events[tick_events.size() - 1].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_t beat_of(input logic [1:0] op, input logic [3:0] slot,
                                  input logic [2:0] wday, input logic [4:0] hour,
                                  input logic [23:0] mask, input logic [2:0] act);
    in_t b;
    b.op          = op;
    b.slot        = slot;
    b.weekday     = wday;
    b.hour        = hour;
    b.hour_mask   = mask;
    b.action_code = act;
    return b;
  endfunction

  function automatic out_t single_event(input logic [3:0] slot, input logic [2:0] act,
                                        input logic on, input logic [6:0] tenths,
                                        input logic restore);
    out_t ev;
    ev.event_slot      = slot;
    ev.event_action    = act;
    ev.switch_on       = on;
    ev.current_tenths  = tenths;
    ev.restore_default = restore;
    ev.last            = 1'b1;
    return ev;
  endfunction

  function automatic in_t random_beat();
    in_t         b;
    int unsigned r;
    b = beat_of(OP_TICK, 4'($urandom_range(15)), 3'(TICK_DAY_STEP * $urandom_range(2)),
                5'($urandom_range(23)), 24'($urandom), 3'($urandom_range(4)));
    r = $urandom_range(99);
    if (r < 50) begin
      if ($urandom_range(9) == 0) begin
        b.hour = 5'($urandom_range(31, 24));
      end
    end else if (r < 75) begin
      b.op      = OP_MASK;
      b.weekday = 3'($urandom_range(6));
      case ($urandom_range(9))
        0:       b.hour_mask = '0;
        1:       b.hour_mask = '1;
        default: ;
      endcase
    end else if (r < 88) begin
      b.op = OP_ACTION;
      if ($urandom_range(4) == 0) begin
        b.action_code = 3'($urandom_range(7));
      end
    end else begin
      case ($urandom_range(2))
        0: b.op = OP_UNUSED;
        1: b.weekday = WDAY_NONE;
        default: begin
          b.op      = OP_MASK;
          b.weekday = WDAY_NONE;
        end
      endcase
    end
    return b;
  endfunction

  task automatic add_row(input logic typed, input logic has_ev, input in_t b,
                         input out_t ev);
    dir_row_t row;
    row           = '0;
    row.typed     = typed;
    row.has_event = has_ev;
    row.beat      = b;
    row.ev        = ev;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [4:0] value);
    dir_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(input in_t b, input logic typed, input logic has_ev,
                           input out_t ev);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 52 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_events(b);
    if (typed) begin
      if (has_ev) begin
        pending_events.push_back(ev);
      end
    end else begin
      foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sched_count = value;
  endtask

  initial begin
    foreach (phase_mem[s]) phase_mem[s] = PH_NONE;
    sched_count  = '0;
    phase_counts = '{5'd16, 5'd31, 5'd0, 5'd7, 5'd17, 5'd1, 5'd16, 5'd15, 5'd0};
    phase_counts[NUM_PHASES - 2] = 5'($urandom_range(31));

    // Directed table: ticks walk slot 0 only, so each tick yields at most one event.
    add_row(1'b1, 1'b0, beat_of(OP_TICK, 4'd0, 3'd0, 5'd0, '0, ACT_ENABLE), '0);
    add_cfg(5'd1);
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd0, 3'd0, 5'd0, '0, ACT_CUR_10A), '0);
    add_row(1'b0, 1'b0, beat_of(OP_MASK, 4'd0, 3'd0, 5'd0, '1, ACT_ENABLE), '0);
    add_row(1'b0, 1'b0, beat_of(OP_MASK, 4'd0, 3'd6, 5'd0, '0, ACT_ENABLE), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd0, 5'd0, '0, ACT_ENABLE),
            single_event(4'd0, ACT_CUR_10A, 1'b1, TENTHS_10A, 1'b0));
    add_row(1'b1, 1'b0, beat_of(OP_TICK, 4'd0, 3'd0, 5'd23, '0, ACT_ENABLE), '0);
    add_cfg(5'd0);
    add_cfg(5'd1);
    add_row(1'b1, 1'b0, beat_of(OP_TICK, 4'd0, 3'd0, 5'd5, '0, ACT_ENABLE), '0);
    add_row(1'b1, 1'b0, beat_of(OP_TICK, 4'd0, WDAY_NONE, 5'd5, '0, ACT_ENABLE), '0);
    add_row(1'b0, 1'b0, beat_of(OP_MASK, 4'd0, WDAY_NONE, 5'd0, '0, ACT_ENABLE), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd6, 5'd0, '0, ACT_ENABLE),
            single_event(4'd0, ACT_CUR_10A, 1'b0, 7'd0, 1'b1));
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd0, 5'd12, '0, ACT_ENABLE),
            single_event(4'd0, ACT_CUR_10A, 1'b1, TENTHS_10A, 1'b0));
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd0, 5'd31, '0, ACT_ENABLE),
            single_event(4'd0, ACT_CUR_10A, 1'b0, 7'd0, 1'b1));
    add_row(1'b1, 1'b0, beat_of(OP_UNUSED, 4'd15, WDAY_NONE, 5'd31, '1, ACT_UNKNOWN), '0);
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd0, 3'd0, 5'd0, '0, ACT_CUR_6A), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd0, 5'd12, '0, ACT_ENABLE),
            single_event(4'd0, ACT_CUR_6A, 1'b1, TENTHS_6A, 1'b0));
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd0, 3'd0, 5'd0, '0, ACT_CUR_8A), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd0, 5'd0, '0, ACT_ENABLE),
            single_event(4'd0, ACT_CUR_8A, 1'b1, TENTHS_8A, 1'b0));
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd0, 3'd0, 5'd0, '0, ACT_UNKNOWN), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd6, 5'd23, '0, ACT_ENABLE),
            single_event(4'd0, ACT_UNKNOWN, 1'b0, 7'd0, 1'b0));
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd0, 3'd0, 5'd0, '0, ACT_ENABLE), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd0, 5'd23, '0, ACT_ENABLE),
            single_event(4'd0, ACT_ENABLE, 1'b1, 7'd0, 1'b0));
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd0, 3'd0, 5'd0, '0, ACT_AVAILABLE), '0);
    add_row(1'b1, 1'b1, beat_of(OP_TICK, 4'd0, 3'd6, 5'd0, '0, ACT_ENABLE),
            single_event(4'd0, ACT_AVAILABLE, 1'b0, 7'd0, 1'b0));
    add_row(1'b0, 1'b0, beat_of(OP_ACTION, 4'd15, 3'd6, 5'd0, '0, ACT_CUR_10A), '0);
    add_row(1'b0, 1'b0, beat_of(OP_MASK, 4'd15, 3'd3, 5'd0, 24'h800001, ACT_ENABLE), '0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_count(dir_rows[i].cfg_value);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].has_event,
                  dir_rows[i].ev);
      end
    end

    // Give every slot an action and the masks of the days that random ticks use.
    idle_mode = IDLE_BOTH;
    for (int s = 0; s < MAX_SCHEDULES; s++) begin
      send_beat(beat_of(OP_ACTION, 4'(s), 3'($urandom_range(7)), 5'($urandom_range(31)),
                        24'($urandom), 3'($urandom_range(7))), 1'b0, 1'b0, '0);
      for (int d = 0; d < DAYS; d += TICK_DAY_STEP) begin
        send_beat(beat_of(OP_MASK, 4'(s), 3'(d), 5'($urandom_range(31)), 24'($urandom),
                          3'($urandom_range(7))), 1'b0, 1'b0, '0);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      idle_mode = idle_mode_e'(p % 4);
      write_count(phase_counts[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        send_beat(random_beat(), 1'b0, 1'b0, '0);
      end
    end
    wait_drained();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
